>>> src/absc_pkg.sv
// Shared types, register map, constants and level functions of the backlight slew block.
package absc_pkg;

    localparam int unsigned SAMPLE_W   = 12;
    localparam int unsigned LEVEL_W    = 8;
    localparam int unsigned PRODUCT_W  = SAMPLE_W + LEVEL_W;
    localparam int unsigned PADDR_W    = 5;
    localparam int unsigned REG_IDX_W  = 3;

    localparam logic [LEVEL_W-1:0]  LCD_SLEW       = 8'd10;
    localparam logic [LEVEL_W-1:0]  BUTTON_SLEW    = 8'd2;
    localparam logic [LEVEL_W-1:0]  LCD_DEADBAND   = 8'd1;
    localparam logic [3:0]          REARM_TICKS    = 4'd12;
    localparam logic [SAMPLE_W-1:0] FULL_DEFAULT   = 12'hC00;

    // Register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_FULL_THR    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_AMBIENT_THR = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LCD_LOW     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LCD_HIGH    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BUTTON_LOW  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BUTTON_HIGH = 3'd5;

    // Result flag positions in m_tuser
    localparam int unsigned FLAG_LCD_WR    = 0;
    localparam int unsigned FLAG_BUTTON_WR = 1;
    localparam int unsigned FLAG_STOCK     = 2;
    localparam int unsigned FLAG_LCD_ADV   = 3;

    typedef struct packed {
        logic [SAMPLE_W-1:0] full_threshold;
        logic [SAMPLE_W-1:0] ambient_threshold;
        logic [LEVEL_W-1:0]  lcd_low_level;
        logic [LEVEL_W-1:0]  lcd_high_level;
        logic [LEVEL_W-1:0]  button_low_level;
        logic [LEVEL_W-1:0]  button_high_level;
    } cfg_t;

    typedef struct packed {
        logic                start;
        logic [SAMPLE_W-1:0] offset;
        logic [LEVEL_W-1:0]  span;
        logic [SAMPLE_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic               wr;
        logic [LEVEL_W-1:0] level;
    } slew_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LCD_START,
        ST_LCD_WAIT,
        ST_BTN_START,
        ST_BTN_WAIT,
        ST_FINISH
    } state_t;

    // Target level from the region flags and the interpolation quotient.
    function automatic logic [LEVEL_W-1:0] map_level(
        input logic               at_low,
        input logic               at_high,
        input logic [LEVEL_W-1:0] low,
        input logic [LEVEL_W-1:0] high,
        input logic [LEVEL_W-1:0] quotient
    );
        logic [LEVEL_W-1:0] level;
        if (at_low) begin
            level = low;
        end else if (at_high || (high < low)) begin
            level = high;
        end else begin
            level = low + quotient;
        end
        return level;
    endfunction

    // Move cur toward tgt by at most step, never past tgt.
    function automatic slew_res_t slew_step(
        input logic [LEVEL_W-1:0] cur,
        input logic [LEVEL_W-1:0] tgt,
        input logic [LEVEL_W-1:0] step
    );
        slew_res_t res;
        res.wr    = (cur != tgt);
        res.level = tgt;
        if (cur > tgt) begin
            if ((cur - tgt) > step) begin
                res.level = cur - step;
            end
        end else if (cur < tgt) begin
            if ((tgt - cur) > step) begin
                res.level = cur + step;
            end
        end else begin
            res.level = cur;
        end
        return res;
    endfunction

endpackage

>>> src/absc_cfg_regs.sv
// APB register file holding thresholds and brightness limits.
module absc_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [absc_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output absc_pkg::cfg_t                cfg
);

    absc_pkg::cfg_t                    cfg_reg;
    logic [absc_pkg::REG_IDX_W-1:0]    reg_idx;
    logic                              wr_en;

    assign reg_idx = paddr[absc_pkg::PADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.full_threshold    <= absc_pkg::FULL_DEFAULT;
            cfg_reg.ambient_threshold <= '0;
            cfg_reg.lcd_low_level     <= '0;
            cfg_reg.lcd_high_level    <= '1;
            cfg_reg.button_low_level  <= '0;
            cfg_reg.button_high_level <= '1;
        end else if (wr_en) begin
            case (reg_idx)
                absc_pkg::REG_FULL_THR:    cfg_reg.full_threshold    <= pwdata[11:0];
                absc_pkg::REG_AMBIENT_THR: cfg_reg.ambient_threshold <= pwdata[11:0];
                absc_pkg::REG_LCD_LOW:     cfg_reg.lcd_low_level     <= pwdata[7:0];
                absc_pkg::REG_LCD_HIGH:    cfg_reg.lcd_high_level    <= pwdata[7:0];
                absc_pkg::REG_BUTTON_LOW:  cfg_reg.button_low_level  <= pwdata[7:0];
                absc_pkg::REG_BUTTON_HIGH: cfg_reg.button_high_level <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            absc_pkg::REG_FULL_THR:    prdata = {20'd0, cfg_reg.full_threshold};
            absc_pkg::REG_AMBIENT_THR: prdata = {20'd0, cfg_reg.ambient_threshold};
            absc_pkg::REG_LCD_LOW:     prdata = {24'd0, cfg_reg.lcd_low_level};
            absc_pkg::REG_LCD_HIGH:    prdata = {24'd0, cfg_reg.lcd_high_level};
            absc_pkg::REG_BUTTON_LOW:  prdata = {24'd0, cfg_reg.button_low_level};
            absc_pkg::REG_BUTTON_HIGH: prdata = {24'd0, cfg_reg.button_high_level};
            default:                   prdata = '0;
        endcase
    end

endmodule

>>> src/absc_interp_div.sv
// Shared multiply and restoring divide unit for the interpolation quotient.
module absc_interp_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  absc_pkg::div_req_t req,
    output absc_pkg::div_rsp_t rsp
);

    localparam int unsigned PW = absc_pkg::PRODUCT_W;
    localparam int unsigned DW = absc_pkg::SAMPLE_W + absc_pkg::LEVEL_W - 1;

    logic [PW-1:0]                  rem_reg;
    logic [DW-1:0]                  dsh_reg;
    logic [absc_pkg::LEVEL_W-1:0]   q_reg;
    logic [2:0]                     cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [PW:0]                    diff;
    logic                           borrow;

    // Trial subtract of the shifted divisor; the quotient is known to fit 8 bits.
    assign diff   = {1'b0, rem_reg} - {{(PW + 1 - DW){1'b0}}, dsh_reg};
    assign borrow = diff[PW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd7;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 3'd1;
                if (cnt_reg == 3'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= req.offset * req.span;
            dsh_reg <= {req.den, {(absc_pkg::LEVEL_W - 1){1'b0}}};
            q_reg   <= '0;
        end else if (busy_reg) begin
            if (!borrow) begin
                rem_reg <= diff[PW-1:0];
            end
            q_reg   <= {q_reg[absc_pkg::LEVEL_W-2:0], ~borrow};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

>>> src/ambient_backlight_slew_controller.sv
// Top level of the ambient backlight slew controller: sequencer, tick update and stream ports.
//
// Usage:
//   One backlight tick enters on the s_ stream: s_tdata carries the filtered
//   ambient sample, s_tuser the three stock transition flags. One result leaves
//   on the m_ stream per tick: the LCD and button levels held after the tick and
//   four flags telling what was written and whether the stock logic owns it.
//   Thresholds and levels are set through the APB port while no tick is in flight.
//
// Sequencing:
//   Each tick maps the sample twice (LCD, then buttons) through one shared
//   multiply and 8-step restoring divider. Each pass has a start step, the divide
//   steps and a done step; a finish step then loads the output register behind m_tvalid.
//   s_tready is high only while the sequencer is idle, so ticks are not overlapped.
//
// Reset and stall:
//   aresetn (synchronous, active low) clears the held levels, the reassert
//   counter and both handshakes, and loads the register defaults. When the
//   receiver stalls, the result holds in the output register and the next tick
//   may be taken; its update waits in the finish step until the output frees.
module ambient_backlight_slew_controller (
    input  logic                         aclk,
    input  logic                         aresetn,
    // s_tdata: [11:0] ambient_sample, [15:12] zero
    input  logic [15:0]                  s_tdata,
    // s_tuser: [0] transition_active, [1] lcd_pending, [2] button_pending
    input  logic [2:0]                   s_tuser,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // m_tdata: [7:0] lcd_level, [15:8] button_level
    output logic [15:0]                  m_tdata,
    // m_tuser: [0] lcd_written, [1] button_written, [2] stock_runs, [3] lcd_stock_step
    output logic [3:0]                   m_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [absc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int unsigned LW = absc_pkg::LEVEL_W;

    absc_pkg::cfg_t     cfg;
    absc_pkg::div_req_t div_req;
    absc_pkg::div_rsp_t div_rsp;
    absc_pkg::state_t   state_reg, state_next;

    logic [absc_pkg::SAMPLE_W-1:0] sample_reg;
    logic                          trans_reg, lpend_reg, bpend_reg;
    logic [LW-1:0]                 lcd_tgt_reg, lcd_tgt_next;
    logic [LW-1:0]                 btn_tgt_reg, btn_tgt_next;
    logic [LW-1:0]                 lcd_cur_reg, lcd_cur_next;
    logic [LW-1:0]                 btn_cur_reg, btn_cur_next;
    logic [3:0]                    reassert_reg, reassert_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [15:0]                   m_tdata_reg, m_tdata_next;
    logic [3:0]                    m_tuser_reg, m_tuser_next;

    logic                          s_xfer, commit;
    logic                          at_low, at_high, use_lcd;
    logic [LW-1:0]                 ch_low, ch_high, mapped;
    logic [3:0]                    ra;
    logic [LW-1:0]                 lcd_delta, lcd_adj, btn_base;
    logic                          lcd_hold;
    absc_pkg::slew_res_t           lcd_sl, btn_sl;
    logic                          lcd_wr, btn_wr, stock, lcd_adv;

    absc_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    absc_interp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_tready = (state_reg == absc_pkg::ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Region of the sample relative to the thresholds, shared by both channels.
    assign at_low  = (sample_reg <= cfg.ambient_threshold);
    assign at_high = (cfg.ambient_threshold >= cfg.full_threshold) ||
                     (sample_reg >= cfg.full_threshold);

    // Pick the channel being mapped from the sequencer state.
    assign use_lcd = (state_reg == absc_pkg::ST_LCD_START) ||
                     (state_reg == absc_pkg::ST_LCD_WAIT);
    assign ch_low  = use_lcd ? cfg.lcd_low_level  : cfg.button_low_level;
    assign ch_high = use_lcd ? cfg.lcd_high_level : cfg.button_high_level;
    assign mapped  = absc_pkg::map_level(at_low, at_high, ch_low, ch_high, div_rsp.quotient);

    always_comb begin
        div_req.start  = (state_reg == absc_pkg::ST_LCD_START) ||
                         (state_reg == absc_pkg::ST_BTN_START);
        div_req.offset = sample_reg - cfg.ambient_threshold;
        // Zero span when levels are inverted; that case maps to the low or the high level anyway.
        div_req.span   = (ch_high >= ch_low) ? (ch_high - ch_low) : '0;
        div_req.den    = cfg.full_threshold - cfg.ambient_threshold;
    end

    // LCD slew with deadband around targets that are not the end levels, and button slew.
    always_comb begin
        lcd_delta = (lcd_cur_reg > lcd_tgt_reg) ? (lcd_cur_reg - lcd_tgt_reg)
                                                : (lcd_tgt_reg - lcd_cur_reg);
        lcd_hold  = 1'b0;
        lcd_adj   = lcd_tgt_reg;
        if ((lcd_tgt_reg != cfg.lcd_low_level) && (lcd_tgt_reg != cfg.lcd_high_level)) begin
            if (lcd_delta <= absc_pkg::LCD_DEADBAND) begin
                lcd_hold = 1'b1;
            end else if (lcd_cur_reg < lcd_tgt_reg) begin
                lcd_adj = lcd_tgt_reg - absc_pkg::LCD_DEADBAND;
            end else begin
                lcd_adj = lcd_tgt_reg + absc_pkg::LCD_DEADBAND;
            end
        end
        lcd_sl   = absc_pkg::slew_step(lcd_cur_reg, lcd_adj, absc_pkg::LCD_SLEW);
        btn_base = bpend_reg ? btn_tgt_reg : btn_cur_reg;
        btn_sl   = absc_pkg::slew_step(btn_base, btn_tgt_reg, absc_pkg::BUTTON_SLEW);
    end

    // Tick update, applied in the finish step.
    always_comb begin
        ra           = (reassert_reg > absc_pkg::REARM_TICKS) ? 4'd0 : reassert_reg;
        lcd_cur_next = lcd_cur_reg;
        btn_cur_next = btn_cur_reg;
        reassert_next = reassert_reg;
        lcd_wr   = 1'b0;
        btn_wr   = 1'b0;
        stock    = 1'b0;
        lcd_adv  = 1'b0;
        if (trans_reg) begin
            reassert_next = absc_pkg::REARM_TICKS;
            stock         = 1'b1;
        end else if (cfg.full_threshold == '0) begin
            stock = 1'b1;
        end else begin
            reassert_next = ra;
            if (bpend_reg) begin
                btn_cur_next = btn_tgt_reg;
                btn_wr       = 1'b1;
            end
            if (lpend_reg) begin
                lcd_adv = 1'b1;
            end else if (ra != 4'd0) begin
                lcd_cur_next  = lcd_tgt_reg;
                btn_cur_next  = btn_tgt_reg;
                lcd_wr        = 1'b1;
                btn_wr        = 1'b1;
                reassert_next = ra - 4'd1;
            end else begin
                if (!lcd_hold) begin
                    lcd_cur_next = lcd_sl.level;
                    lcd_wr       = lcd_sl.wr;
                end
                btn_cur_next = btn_sl.level;
                btn_wr       = btn_wr || btn_sl.wr;
            end
        end
    end

    // Sequencer: next state, target capture and output register loading.
    always_comb begin
        state_next    = state_reg;
        lcd_tgt_next  = lcd_tgt_reg;
        btn_tgt_next  = btn_tgt_reg;
        commit        = 1'b0;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        case (state_reg)
            absc_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    state_next = absc_pkg::ST_LCD_START;
                end
            end
            absc_pkg::ST_LCD_START: state_next = absc_pkg::ST_LCD_WAIT;
            absc_pkg::ST_LCD_WAIT: begin
                if (div_rsp.done) begin
                    lcd_tgt_next = mapped;
                    state_next   = absc_pkg::ST_BTN_START;
                end
            end
            absc_pkg::ST_BTN_START: state_next = absc_pkg::ST_BTN_WAIT;
            absc_pkg::ST_BTN_WAIT: begin
                if (div_rsp.done) begin
                    btn_tgt_next = mapped;
                    state_next   = absc_pkg::ST_FINISH;
                end
            end
            absc_pkg::ST_FINISH: begin
                // Hold until the output register is free.
                if (!m_tvalid_reg || m_tready) begin
                    commit       = 1'b1;
                    m_tdata_next = {btn_cur_next, lcd_cur_next};
                    m_tuser_next = {lcd_adv, stock, btn_wr, lcd_wr};
                    state_next   = absc_pkg::ST_IDLE;
                end
            end
            default: state_next = absc_pkg::ST_IDLE;
        endcase
        m_tvalid_next = commit || (m_tvalid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= absc_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
            lcd_cur_reg  <= '0;
            btn_cur_reg  <= '0;
            reassert_reg <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (commit) begin
                lcd_cur_reg  <= lcd_cur_next;
                btn_cur_reg  <= btn_cur_next;
                reassert_reg <= reassert_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            sample_reg <= s_tdata[absc_pkg::SAMPLE_W-1:0];
            trans_reg  <= s_tuser[0];
            lpend_reg  <= s_tuser[1];
            bpend_reg  <= s_tuser[2];
        end
        lcd_tgt_reg <= lcd_tgt_next;
        btn_tgt_reg <= btn_tgt_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    // One tick in flight: an input transfer closes the input side.
    a_single_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> !s_tready)
        else $error("input accepted while a tick is in flight");

    // The reassert counter never leaves its window once updated.
    a_reassert_range: assert property (@(posedge aclk) disable iff (!aresetn)
        reassert_reg <= absc_pkg::REARM_TICKS)
        else $error("reassert counter out of range");

    // Divider results arrive only while the sequencer waits for them.
    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == absc_pkg::ST_LCD_WAIT ||
                          state_reg == absc_pkg::ST_BTN_WAIT))
        else $error("divider done outside a wait step");

    // A stock tick writes nothing.
    a_stock_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tuser_reg[absc_pkg::FLAG_STOCK]) |->
        !(m_tuser_reg[absc_pkg::FLAG_LCD_WR] || m_tuser_reg[absc_pkg::FLAG_BUTTON_WR] ||
          m_tuser_reg[absc_pkg::FLAG_LCD_ADV]))
        else $error("stock tick reports a write");

    // A new result is only loaded when the previous one was taken or absent.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |-> (!m_tvalid_reg || m_tready))
        else $error("result overwritten before transfer");

endmodule

>>> test/tb.sv
// Self-checking bench for the ambient backlight slew controller: directed and random ticks.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles without any transfer before the run is declared hung. The slowest
    // legitimate stretch is the long receiver hold plus one tick.
    localparam int unsigned HANG_LIMIT = 4000;
    localparam int unsigned LONG_HOLD  = 400;
    // Idle time after the last result before a register write or the verdict.
    localparam int unsigned SETTLE_CYCLES = 30;

    // One result item as the block reports it.
    typedef struct {
        logic [absc_pkg::LEVEL_W-1:0] lcd;
        logic [absc_pkg::LEVEL_W-1:0] button;
        logic                         lcd_wr;
        logic                         button_wr;
        logic                         stock;
        logic                         lcd_adv;
    } tick_result_t;

    logic                          aclk;
    logic                          aresetn;
    logic [15:0]                   s_tdata;
    logic [2:0]                    s_tuser;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [15:0]                   m_tdata;
    logic [3:0]                    m_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [absc_pkg::PADDR_W-1:0]  paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;

    // Predictor copy of the register file and of the held levels.
    absc_pkg::cfg_t                shadow_cfg;
    logic [absc_pkg::LEVEL_W-1:0]  lcd_held;
    logic [absc_pkg::LEVEL_W-1:0]  button_held;
    logic [3:0]                    reassert_count;

    tick_result_t        level_queue[$];

    int unsigned         mismatch_count;
    int unsigned         idle_cycles;
    int unsigned         send_idle_pct;
    int unsigned         recv_stall_pct;
    int unsigned         stall_left;
    bit                  long_hold_req;

    ambient_backlight_slew_controller i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Map a sample onto a level: low up to the ambient threshold, high from the
    // full threshold on, truncated linear interpolation in between, clamped.
    function automatic logic [absc_pkg::LEVEL_W-1:0] target_level(int sample, int lo_thr,
                                                                  int hi_thr, int low,
                                                                  int high);
        int level;
        if (sample <= lo_thr) begin
            return low[absc_pkg::LEVEL_W-1:0];
        end
        if (lo_thr >= hi_thr || sample >= hi_thr) begin
            return high[absc_pkg::LEVEL_W-1:0];
        end
        level = low + ((sample - lo_thr) * (high - low)) / (hi_thr - lo_thr);
        if (level < low) begin
            level = low;
        end
        if (level > high) begin
            level = high;
        end
        return level[absc_pkg::LEVEL_W-1:0];
    endfunction

    // Step a level toward tgt by at most step; report whether it moved.
    function automatic bit move_toward(inout logic [absc_pkg::LEVEL_W-1:0] lvl,
                                       input int tgt, input int step);
        int cur;
        int nxt;
        cur = int'(lvl);
        if (cur == tgt) begin
            return 1'b0;
        end
        if (cur > tgt) begin
            nxt = cur - step;
            if (nxt < tgt) begin
                nxt = tgt;
            end
        end else begin
            nxt = cur + step;
            if (nxt > tgt) begin
                nxt = tgt;
            end
        end
        lvl = nxt[absc_pkg::LEVEL_W-1:0];
        return 1'b1;
    endfunction

    // LCD slew with deadband: intermediate targets are ignored when close and
    // otherwise approached only to one short of the target.
    function automatic bit lcd_approach(logic [absc_pkg::LEVEL_W-1:0] tgt);
        int cur;
        int adj;
        int delta;
        cur   = int'(lcd_held);
        adj   = int'(tgt);
        delta = cur - adj;
        if (delta < 0) begin
            delta = -delta;
        end
        if (tgt != shadow_cfg.lcd_low_level && tgt != shadow_cfg.lcd_high_level) begin
            if (delta <= int'(absc_pkg::LCD_DEADBAND)) begin
                return 1'b0;
            end
            if (cur < adj) begin
                adj -= int'(absc_pkg::LCD_DEADBAND);
            end else begin
                adj += int'(absc_pkg::LCD_DEADBAND);
            end
        end
        return move_toward(lcd_held, adj, int'(absc_pkg::LCD_SLEW));
    endfunction

    // Advance the predicted levels by one tick and return what the block reports.
    function automatic tick_result_t advance_backlight(logic [absc_pkg::SAMPLE_W-1:0] sample,
                                                       logic trans, logic lcd_pend,
                                                       logic btn_pend);
        tick_result_t                 r;
        logic [absc_pkg::LEVEL_W-1:0] lcd_tgt;
        logic [absc_pkg::LEVEL_W-1:0] btn_tgt;
        r = '{default: '0};
        if (trans) begin
            // Stock transition owns the tick and rearms the reassert window.
            reassert_count = absc_pkg::REARM_TICKS;
            r.stock = 1'b1;
        end else if (shadow_cfg.full_threshold == '0) begin
            r.stock = 1'b1;
        end else begin
            if (reassert_count > absc_pkg::REARM_TICKS) begin
                reassert_count = '0;
            end
            lcd_tgt = target_level(int'(sample), int'(shadow_cfg.ambient_threshold),
                                   int'(shadow_cfg.full_threshold),
                                   int'(shadow_cfg.lcd_low_level),
                                   int'(shadow_cfg.lcd_high_level));
            btn_tgt = target_level(int'(sample), int'(shadow_cfg.ambient_threshold),
                                   int'(shadow_cfg.full_threshold),
                                   int'(shadow_cfg.button_low_level),
                                   int'(shadow_cfg.button_high_level));
            if (btn_pend) begin
                button_held = btn_tgt;
                r.button_wr = 1'b1;
            end
            if (lcd_pend) begin
                r.lcd_adv = 1'b1;
            end else if (reassert_count != '0) begin
                lcd_held       = lcd_tgt;
                button_held    = btn_tgt;
                r.lcd_wr       = 1'b1;
                r.button_wr    = 1'b1;
                reassert_count = reassert_count - 4'd1;
            end else begin
                r.lcd_wr = lcd_approach(lcd_tgt);
                if (move_toward(button_held, int'(btn_tgt), int'(absc_pkg::BUTTON_SLEW))) begin
                    r.button_wr = 1'b1;
                end
            end
        end
        r.lcd    = lcd_held;
        r.button = button_held;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Compare every result transfer with the oldest prediction.
    always @(posedge aclk) begin : check_results
        tick_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (level_queue.size() == 0) begin
                report_mismatch("result with nothing predicted, lcd_level",
                                int'(m_tdata[7:0]), -1);
            end else begin
                want = level_queue.pop_front();
                if (m_tdata[7:0] != want.lcd) begin
                    report_mismatch("lcd_level", int'(m_tdata[7:0]), int'(want.lcd));
                end
                if (m_tdata[15:8] != want.button) begin
                    report_mismatch("button_level", int'(m_tdata[15:8]), int'(want.button));
                end
                if (m_tuser[absc_pkg::FLAG_LCD_WR] != want.lcd_wr) begin
                    report_mismatch("lcd_written", int'(m_tuser[absc_pkg::FLAG_LCD_WR]),
                                    int'(want.lcd_wr));
                end
                if (m_tuser[absc_pkg::FLAG_BUTTON_WR] != want.button_wr) begin
                    report_mismatch("button_written", int'(m_tuser[absc_pkg::FLAG_BUTTON_WR]),
                                    int'(want.button_wr));
                end
                if (m_tuser[absc_pkg::FLAG_STOCK] != want.stock) begin
                    report_mismatch("stock_runs", int'(m_tuser[absc_pkg::FLAG_STOCK]),
                                    int'(want.stock));
                end
                if (m_tuser[absc_pkg::FLAG_LCD_ADV] != want.lcd_adv) begin
                    report_mismatch("lcd_stock_step", int'(m_tuser[absc_pkg::FLAG_LCD_ADV]),
                                    int'(want.lcd_adv));
                end
            end
        end
    end

    // Hang detection: count cycles with no stream transfer and no APB access.
    always @(posedge aclk) begin
        if (!aresetn || psel || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= HANG_LIMIT) begin
            $display("[%0t] no transfer for %0d cycles", $realtime, HANG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: short random stalls per the current mode, plus one long hold
    // on request, counted down here.
    always @(negedge aclk) begin
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left    = LONG_HOLD;
        end
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 99) < recv_stall_pct) begin
            m_tready   <= 1'b0;
            stall_left = $urandom_range(0, 6);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Drivers. Every task is entered and left at a falling edge.
    // ------------------------------------------------------------------

    // Offer one tick, hold it until the transfer, then log the prediction.
    // Valid is only dropped when a gap is inserted, so it never toggles in one step.
    task automatic send_tick(logic [absc_pkg::SAMPLE_W-1:0] sample, logic trans,
                             logic lcd_pend, logic btn_pend);
        int unsigned gap;
        gap = 0;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            gap = $urandom_range(1, 30);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, sample};
        s_tuser  <= {btn_pend, lcd_pend, trans};
        do @(posedge aclk); while (!s_tready);
        level_queue.push_back(advance_backlight(sample, trans, lcd_pend, btn_pend));
        @(negedge aclk);
    endtask

    // Drop valid and wait until every predicted result has come out, then
    // let the block go quiet.
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (level_queue.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // APB write: setup cycle, access cycle, register taken at the ready edge.
    task automatic apb_write(logic [absc_pkg::REG_IDX_W-1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            absc_pkg::REG_FULL_THR:
                shadow_cfg.full_threshold    = value[absc_pkg::SAMPLE_W-1:0];
            absc_pkg::REG_AMBIENT_THR:
                shadow_cfg.ambient_threshold = value[absc_pkg::SAMPLE_W-1:0];
            absc_pkg::REG_LCD_LOW:
                shadow_cfg.lcd_low_level     = value[absc_pkg::LEVEL_W-1:0];
            absc_pkg::REG_LCD_HIGH:
                shadow_cfg.lcd_high_level    = value[absc_pkg::LEVEL_W-1:0];
            absc_pkg::REG_BUTTON_LOW:
                shadow_cfg.button_low_level  = value[absc_pkg::LEVEL_W-1:0];
            absc_pkg::REG_BUTTON_HIGH:
                shadow_cfg.button_high_level = value[absc_pkg::LEVEL_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    // Rewrite the whole register file while the block is idle.
    task automatic apply_config(int full, int amb, int lcd_lo, int lcd_hi, int btn_lo,
                                int btn_hi);
        settle_block();
        apb_write(absc_pkg::REG_FULL_THR, full);
        apb_write(absc_pkg::REG_AMBIENT_THR, amb);
        apb_write(absc_pkg::REG_LCD_LOW, lcd_lo);
        apb_write(absc_pkg::REG_LCD_HIGH, lcd_hi);
        apb_write(absc_pkg::REG_BUTTON_LOW, btn_lo);
        apb_write(absc_pkg::REG_BUTTON_HIGH, btn_hi);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset defaults: dark, full, mid-scale and back to full, all plain slews.
    task automatic test_default_mapping();
        send_tick(12'd0, 1'b0, 1'b0, 1'b0);
        send_tick(12'd4095, 1'b0, 1'b0, 1'b0);
        send_tick(12'd2048, 1'b0, 1'b0, 1'b0);
        send_tick(12'd4095, 1'b0, 1'b0, 1'b0);
    endtask

    // Stock transition, reassert window, queued button and LCD transitions.
    task automatic test_stock_flags();
        send_tick(12'd1000, 1'b1, 1'b0, 1'b0);
        send_tick(12'd4095, 1'b0, 1'b0, 1'b0);
        send_tick(12'd0, 1'b0, 1'b0, 1'b1);
        // queued LCD step holds the window count
        send_tick(12'd2000, 1'b0, 1'b1, 1'b0);
        send_tick(12'd3000, 1'b0, 1'b1, 1'b1);
        send_tick(12'd4095, 1'b1, 1'b1, 1'b1);
        send_tick(12'd1500, 1'b0, 1'b0, 1'b0);
        send_tick(12'd1500, 1'b0, 1'b0, 1'b0);
        send_tick(12'd2500, 1'b0, 1'b0, 1'b0);
    endtask

    // Inverted levels, swapped thresholds and stock bypass.
    task automatic test_level_shapes();
        apply_config(3000, 1000, 200, 50, 255, 0);
        send_tick(12'd500, 1'b0, 1'b0, 1'b0);
        send_tick(12'd2000, 1'b0, 1'b0, 1'b0);
        send_tick(12'd4095, 1'b0, 1'b0, 1'b0);
        // ambient threshold above full: anything past ambient is the high level
        apply_config(100, 2000, 10, 240, 30, 220);
        send_tick(12'd2001, 1'b0, 1'b0, 1'b0);
        send_tick(12'd2000, 1'b0, 1'b0, 1'b0);
        send_tick(12'd4095, 1'b0, 1'b1, 1'b1);
        apply_config(0, 0, 0, 255, 0, 255);
        send_tick(12'd100, 1'b0, 1'b1, 1'b1);
        send_tick(12'd100, 1'b1, 1'b0, 1'b0);
    endtask

    // Random phases: each with its own register setting and idle mode. Samples
    // follow a slow walk with jumps so slews, deadband and thresholds are all hit.
    task automatic test_random_phases();
        int          full;
        int          amb;
        int          lcd_lo;
        int          btn_lo;
        int          walk;
        int          ticks;
        int unsigned roll;
        logic [2:0]  flags;
        for (int phase = 0; phase < 9; phase++) begin
            full   = $urandom_range(1, 4095);
            amb    = $urandom_range(0, full - 1);
            lcd_lo = $urandom_range(1, 255);
            btn_lo = $urandom_range(1, 255);
            case (phase)
                0: apply_config(4095, 0, 0, 255, 0, 255);
                2: apply_config(full, amb, lcd_lo, $urandom_range(0, lcd_lo - 1),
                                btn_lo, $urandom_range(0, btn_lo - 1));
                3: apply_config(full, $urandom_range(full, 4095), $urandom_range(0, 255),
                                $urandom_range(0, 255), $urandom_range(0, 255),
                                $urandom_range(0, 255));
                4: apply_config(1, 0, $urandom_range(0, 255), $urandom_range(0, 255),
                                $urandom_range(0, 255), $urandom_range(0, 255));
                5: apply_config(0, $urandom_range(0, 4095), $urandom_range(0, 255),
                                $urandom_range(0, 255), $urandom_range(0, 255),
                                $urandom_range(0, 255));
                6: apply_config(4095, 4094, 255, 255, 255, 0);
                default: apply_config(full, amb, $urandom_range(0, 255),
                                      $urandom_range(0, 255), $urandom_range(0, 255),
                                      $urandom_range(0, 255));
            endcase
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            ticks = (phase == 5) ? 40 : 225;
            walk  = $urandom_range(0, 4095);
            for (int n = 0; n < ticks; n++) begin
                // long receiver hold while ticks keep coming: fill and stall the input
                if (phase == 2 && n == 20) begin
                    long_hold_req = 1'b1;
                end
                // pause the sender until everything has drained
                if (phase == 4 && n == ticks / 2) begin
                    settle_block();
                end
                roll = $urandom_range(0, 99);
                if (roll < 15) begin
                    walk = $urandom_range(0, 4095);
                end else if (roll < 25) begin
                    walk = ($urandom_range(0, 1) ? int'(shadow_cfg.ambient_threshold)
                                                 : int'(shadow_cfg.full_threshold))
                           + $urandom_range(0, 6) - 3;
                end else begin
                    walk = walk + $urandom_range(0, 80) - 40;
                end
                if (walk < 0) begin
                    walk = 0;
                end
                if (walk > 4095) begin
                    walk = 4095;
                end
                // mostly sparse stock activity, some noise with any flag mix
                if ($urandom_range(0, 99) < 5) begin
                    flags = 3'($urandom());
                end else begin
                    flags[0] = ($urandom_range(0, 99) < 3);
                    flags[1] = ($urandom_range(0, 99) < 8);
                    flags[2] = ($urandom_range(0, 99) < 8);
                end
                send_tick(walk[absc_pkg::SAMPLE_W-1:0], flags[0], flags[1], flags[2]);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        m_tready       = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        aresetn        = 1'b0;
        mismatch_count = 0;
        idle_cycles    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        stall_left     = 0;
        long_hold_req  = 1'b0;

        // predictor starts from the reset register file and zero levels
        shadow_cfg.full_threshold    = absc_pkg::FULL_DEFAULT;
        shadow_cfg.ambient_threshold = '0;
        shadow_cfg.lcd_low_level     = '0;
        shadow_cfg.lcd_high_level    = 8'd255;
        shadow_cfg.button_low_level  = '0;
        shadow_cfg.button_high_level = 8'd255;
        lcd_held       = '0;
        button_held    = '0;
        reassert_count = '0;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        test_default_mapping();
        test_stock_flags();
        test_level_shapes();
        test_random_phases();

        settle_block();
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
